// File: hw/rtl/sliding_window_max_assert.svh
// assertion macros for the sliding window maximum block
`ifndef SLIDING_WINDOW_MAX_ASSERT_SVH
`define SLIDING_WINDOW_MAX_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define SWM_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/swm_pkg.sv
// shared types, constants and helpers of the sliding window maximum block
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WSIZE_W        = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0
  } reg_idx_e;

  function automatic sample_t smax(input sample_t a, input sample_t b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/swm_cell.sv
// one cell of the chain: holds the maximum of the newest k+1 samples
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  logic    restart_i,
  input  sample_t sample_i,
  input  sample_t prev_i,
  output sample_t max_o,
  output sample_t next_o
);

  sample_t max_q;
  sample_t max_d;

  // older samples drop out on restart, otherwise merge with the neighbor's prefix
  always_comb begin
    if (restart_i) begin
      max_d = sample_i;
    end else begin
      max_d = smax(sample_i, prev_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o  = max_q;
  assign next_o = max_d;

endmodule

`default_nettype wire

// File: hw/rtl/swm_chain.sv
// row of prefix-maximum cells with a tap select on the updated values
`default_nettype none

module swm_chain
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  logic             start_i,
  input  sample_t          sample_i,
  input  logic [IDX_W-1:0] sel_i,
  output sample_t          sel_max_o
);

  sample_t cell_max [WINDOW_MAX];
  sample_t cell_next[WINDOW_MAX];

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (shift_en_i),
        .restart_i(1'b1),
        .sample_i (sample_i),
        .prev_i   (sample_i),
        .max_o    (cell_max[k]),
        .next_o   (cell_next[k])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (shift_en_i),
        .restart_i(start_i),
        .sample_i (sample_i),
        .prev_i   (cell_max[k-1]),
        .max_o    (cell_max[k]),
        .next_o   (cell_next[k])
      );
    end
  end

  assign sel_max_o = cell_next[sel_i];

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_max.sv
// top level of the sliding window maximum block
//
//   channel   signals                                        direction
//   input     in_valid_i, in_ready_o, sample_i, start_req_i  in
//   output    out_valid_o, out_ready_i, window_max_o         out
//   config    psel, penable, pwrite, paddr, pwdata, prdata   apb
//
// one sample per cycle while not stalled; a result is registered at its transfer
// each cell updates its prefix maximum with a single compare against its neighbor
// the output register takes a new result in the cycle the old one leaves
// reset clears the fill count, the window size to 1 and the output valid
// no clearing pass; results from cells past the fill count are never marked valid
`default_nettype none

`include "sliding_window_max_assert.svh"

module sliding_window_max
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sample_t               sample_i,
  input  logic                  start_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sample_t               window_max_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW    = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

  logic [WSIZE_W-1:0] window_size_q;
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic               out_valid_q, out_valid_d;
  sample_t            out_max_q, out_max_d;

  logic               in_xfer;
  logic               cfg_wr;
  reg_idx_e           reg_idx;
  logic [EW-1:0]      ws_ext, w_eff, filled_ext;
  logic [IDX_W-1:0]   sel;
  logic               has_result;
  sample_t            sel_max;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_WINDOW_SIZE: prdata = APB_DATA_W'(window_size_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WSIZE_W'(1);
    end else if (cfg_wr && (reg_idx == REG_WINDOW_SIZE)) begin
      window_size_q <= pwdata[WSIZE_W-1:0];
    end
  end

  // effective window
  assign ws_ext = EW'(window_size_q);

  always_comb begin
    if (ws_ext == '0) begin
      w_eff = EW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      w_eff = EW'(WINDOW_MAX);
    end else begin
      w_eff = ws_ext;
    end
  end

  assign sel = IDX_W'(w_eff - EW'(1));

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // fill count, saturating
  always_comb begin
    if (start_req_i) begin
      filled_d = CNT_W'(1);
    end else if (filled_q == CNT_W'(WINDOW_MAX)) begin
      filled_d = filled_q;
    end else begin
      filled_d = filled_q + CNT_W'(1);
    end
  end

  assign filled_ext = EW'(filled_d);
  assign has_result = (filled_ext >= w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (in_xfer) begin
      filled_q <= filled_d;
    end
  end

  swm_chain #(
    .WINDOW_MAX(WINDOW_MAX),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk_i     (clk_i),
    .shift_en_i(in_xfer),
    .start_i   (start_req_i),
    .sample_i  (sample_i),
    .sel_i     (sel),
    .sel_max_o (sel_max)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_max_d   = out_max_q;
    if (in_xfer) begin
      out_valid_d = has_result;
      out_max_d   = sel_max;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_max_q <= out_max_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_max_q;

  `SWM_ASSERT_NEXT(a_start_fill, in_xfer && start_req_i, filled_q == CNT_W'(1), "fill count not reset by start")
  `SWM_ASSERT_NEXT(a_unit_window, in_xfer && (w_eff == EW'(1)), out_valid_o && (window_max_o == $past(sample_i)), "unit window result wrong")
  `SWM_ASSERT_SAME(a_fill_bound, 1'b1, filled_q <= CNT_W'(WINDOW_MAX), "fill count overflow")
  `SWM_ASSERT_SAME(a_result_src, $rose(out_valid_o), $past(in_valid_i && in_ready_o), "result without input transfer")

endmodule

`default_nettype wire

// File: test/sliding_window_max_tb.sv
// self-checking testbench of the sliding window maximum block with random flow control
module sliding_window_max_tb
  import swm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS    = 1250;
  localparam int CALM_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int MAX_REPORTS   = 10;
  localparam int REG_SPARE_IDX = 1;

  localparam logic [APB_ADDR_W-1:0] WSIZE_ADDR = APB_ADDR_W'(4 * REG_WINDOW_SIZE);
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * REG_SPARE_IDX);

  localparam sample_t SMIN = 32'h8000_0000;
  localparam sample_t SMAX = 32'h7fff_ffff;

  typedef struct packed {
    sample_t sample;
    logic    start;
  } sample_item_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  sample_t               sample_i     = '0;
  logic                  start_req_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  sample_t               window_max_o;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sample_item_t sample_q[$];
  sample_t      window_max_q[$];
  int           samples_queued = 0;
  int           samples_taken  = 0;
  logic         sample_taken   = 1'b0;
  int           fail_cnt       = 0;
  int           stall_cycles   = 0;
  bit           calm           = 1'b0;
  int           in_gap         = 0;
  int           out_gap        = 0;

  sample_t          sample_hist [WINDOW_MAX_DEF];
  logic [5:0]       wr_pos    = '0;
  int               fill_cnt  = 0;
  logic [WSIZE_W-1:0] wsize_cfg = 7'd1;

  sliding_window_max i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .window_max_o(window_max_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int eff_window(input logic [WSIZE_W-1:0] wsz);
    if (wsz == 0) return 1;
    if (wsz > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return int'(wsz);
  endfunction

  function automatic bit window_max_step(input sample_t s, input logic start,
                                         output sample_t mx);
    int         w;
    logic [5:0] idx;
    if (start) begin
      wr_pos   = '0;
      fill_cnt = 0;
    end
    sample_hist[wr_pos] = s;
    wr_pos = wr_pos + 6'd1;
    if (fill_cnt < WINDOW_MAX_DEF) fill_cnt++;
    w  = eff_window(wsize_cfg);
    mx = s;
    if (fill_cnt < w) return 1'b0;
    for (int i = 1; i < w; i++) begin
      idx = wr_pos - 6'd1 - 6'(i);
      if (sample_hist[idx] > mx) mx = sample_hist[idx];
    end
    return 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMIN;
      1:       return SMAX;
      2, 3:    return sample_t'(int'($urandom_range(0, 15)) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic push_item(input sample_t s, input logic st);
    sample_q.push_back('{sample: s, start: st});
    samples_queued++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (samples_taken != samples_queued || window_max_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [WSIZE_W-1:0] val);
    logic [APB_DATA_W-1:0] data;
    data = $urandom();
    data[WSIZE_W-1:0] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [APB_ADDR_W-1:0] addr, input logic [WSIZE_W-1:0] val);
    drain();
    apb_write(addr, val);
    @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin : drv
    sample_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !sample_taken)) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= $urandom_range(0, 18);
      end else if (sample_q.size() != 0) begin
        it          = sample_q.pop_front();
        in_valid_i  <= 1'b1;
        sample_i    <= it.sample;
        start_req_i <= it.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    if (out_gap != 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : mon
    sample_t mx;
    sample_t want;
    bit      busy;
    sample_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      busy = 1'b0;
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        if (paddr == WSIZE_ADDR) wsize_cfg = pwdata[WSIZE_W-1:0];
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        samples_taken++;
        if (window_max_step(sample_i, start_req_i, mx)) window_max_q.push_back(mx);
      end
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        if (window_max_q.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("window_max %0d transferred with no result pending", window_max_o);
          fail_cnt++;
        end else begin
          want = window_max_q.pop_front();
          if (window_max_o !== want) begin
            if (fail_cnt < MAX_REPORTS)
              $display("window_max mismatch: expected %0d, got %0d", want, window_max_o);
            fail_cnt++;
          end
        end
      end
      stall_cycles = busy ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stim
    int                 rand_cnt;
    int                 w;
    int                 nseq;
    int                 len;
    bit                 fresh;
    logic [WSIZE_W-1:0] wsz;
    rand_cnt = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stream from reset without a start, window of one
    push_item(SMIN, 1'b0);
    push_item(SMAX, 1'b0);
    push_item(sample_t'(0), 1'b0);
    push_item(sample_t'(-1), 1'b0);

    set_window(WSIZE_ADDR, 7'd3);
    push_item(SMIN, 1'b1);
    push_item(SMIN, 1'b0);
    push_item(SMAX, 1'b0);
    push_item(sample_t'(5), 1'b0);
    push_item(sample_t'(5), 1'b0);
    push_item(sample_t'(5), 1'b0);

    set_window(WSIZE_ADDR, 7'd0);
    push_item(pick_sample(), 1'b1);
    push_item(pick_sample(), 1'b0);

    // saturated window, sequence too short for a result
    set_window(WSIZE_ADDR, 7'd127);
    push_item(sample_t'(7), 1'b1);
    push_item(SMIN, 1'b0);
    push_item(sample_t'(-3), 1'b0);
    push_item(SMAX, 1'b0);

    // shrink mid-sequence
    set_window(WSIZE_ADDR, 7'd2);
    push_item(sample_t'(-9), 1'b0);
    push_item(SMIN, 1'b0);

    set_window(SPARE_ADDR, 7'd9);
    push_item(sample_t'(1), 1'b0);
    push_item(sample_t'(-1), 1'b0);

    while (rand_cnt < RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0:          wsz = 7'd64;
        1:          wsz = 7'd0;
        2:          wsz = 7'($urandom_range(65, 127));
        3, 4, 5:    wsz = 7'($urandom_range(1, 64));
        default:    wsz = 7'($urandom_range(1, 8));
      endcase
      if (rand_cnt >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      set_window(WSIZE_ADDR, wsz);
      w     = eff_window(wsz);
      fresh = $urandom_range(0, 4) != 0;
      nseq  = $urandom_range(1, 4);
      for (int s = 0; s < nseq; s++) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, w);
        else len = w + $urandom_range(0, 40);
        for (int k = 0; k < len; k++) begin
          push_item(pick_sample(),
                    (k == 0 && (fresh || s > 0)) || $urandom_range(0, 31) == 0);
          rand_cnt++;
        end
      end
    end

    drain();
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: sliding_window_max.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_chain.sv
hw/rtl/sliding_window_max.sv
test/sliding_window_max_tb.sv
